[design/sst_pkg.sv]
package sst_pkg;

  localparam int KIND_W     = 2;
  localparam int KEY_PORT_W = 64;
  localparam int POS_W      = 9;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 9;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOCHG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

endpackage

[design/sst_ram.sv]
module sst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sorted_set_table.sv]
// A request runs S search steps (at most clog2(DEPTH+1)), each a read then a compare; an insert
// or remove that changes the set then moves N entries, and an insert writes its key last.
// Throughput: one request in flight; the next is accepted the cycle after its result is
// registered, and a result not yet taken holds the block at the response step.
// Reset (rst_n low, synchronous): key count cleared, capacity back to 256,
// no result pending. Key storage is not cleared.
module sorted_set_table #(
  parameter int DEPTH    = 256,
  parameter int KEY_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sst_pkg::KIND_W-1:0]     in_kind,
  input  logic [sst_pkg::KEY_PORT_W-1:0] in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [sst_pkg::POS_W-1:0]      out_position,
  output logic [sst_pkg::STATUS_W-1:0]   out_status,
  output logic [sst_pkg::POS_W-1:0]      out_element_count,
  input  logic                           cfg_we,
  input  logic [sst_pkg::CAP_W-1:0]      cfg_wdata
);
  import sst_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_SHIFT, S_PUT, S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hix_r, hix_nxt;   // exclusive upper bound
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic                 hit_r, hit_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [CNT_W-1:0]     src_r, src_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     wa_r, wa_nxt;
  logic                 pend_r, pend_nxt;
  logic                 up_r, up_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [POS_W-1:0]     out_count_r, out_count_nxt;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0]  ram_wdata, ram_rdata;

  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid_now;
  logic                 key_lt, key_gt;
  logic [CNT_W-1:0]     lo_step, hix_step;
  logic                 full;
  logic [CW-1:0]        pos_ext, used_ext;

  sst_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid_sum = ({1'b0, lo_r} + {1'b0, hix_r} - (CNT_W+1)'(1)) >> 1;
  assign mid_now = mid_sum[CNT_W-1:0];

  // the one comparator, shared by every search step
  assign key_lt = key_r < ram_rdata;
  assign key_gt = key_r > ram_rdata;

  assign lo_step  = key_gt ? mid_r + CNT_W'(1) : lo_r;
  assign hix_step = key_lt ? mid_r : hix_r;

  // used >= min(capacity, DEPTH)
  assign full = (CW'(used_r) >= CW'(cap_r)) || (used_r >= CNT_W'(DEPTH));

  assign pos_ext  = CW'(pos_r);
  assign used_ext = CW'(used_r);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hix_nxt        = hix_r;
    mid_nxt        = mid_r;
    hit_nxt        = hit_r;
    pos_nxt        = pos_r;
    used_nxt       = used_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    src_nxt        = src_r;
    cnt_nxt        = cnt_r;
    wa_nxt         = wa_r;
    pend_nxt       = pend_r;
    up_nxt         = up_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    ram_we    = 1'b0;
    ram_waddr = wa_r[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = mid_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          key_nxt  = in_key[KEY_BITS-1:0];
          lo_nxt   = '0;
          hix_nxt  = used_r;
          hit_nxt  = 1'b0;
          pos_nxt  = '0;
          state_nxt = (used_r != '0) ? S_SRCH_RD : S_DECIDE;
        end
      end
      S_SRCH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = mid_now[IDX_W-1:0];
        mid_nxt   = mid_now;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (!key_lt && !key_gt) begin
          hit_nxt   = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = S_DECIDE;
        end else begin
          lo_nxt  = lo_step;
          hix_nxt = hix_step;
          if (lo_step < hix_step) begin
            state_nxt = S_SRCH_RD;
          end else begin
            pos_nxt   = lo_step;
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        pend_nxt  = 1'b0;
        state_nxt = S_RESP;
        case (kind_r)
          KIND_INSERT: begin
            if (full) begin
              status_nxt = STATUS_FULL;
            end else if (hit_r) begin
              status_nxt = STATUS_NOCHG;
            end else begin
              status_nxt = STATUS_OK;
              up_nxt     = 1'b1;
              cnt_nxt    = used_r - pos_r;
              src_nxt    = used_r - CNT_W'(1);
              used_nxt   = used_r + CNT_W'(1);
              state_nxt  = S_SHIFT;
            end
          end
          KIND_REMOVE: begin
            if (hit_r) begin
              status_nxt = STATUS_OK;
              up_nxt     = 1'b0;
              cnt_nxt    = used_r - pos_r - CNT_W'(1);
              src_nxt    = pos_r + CNT_W'(1);
              used_nxt   = used_r - CNT_W'(1);
              state_nxt  = S_SHIFT;
            end else begin
              status_nxt = STATUS_NOCHG;
            end
          end
          default: begin
            status_nxt = hit_r ? STATUS_OK : STATUS_NOCHG;
          end
        endcase
      end
      S_SHIFT: begin
        // read one entry while any remain and write back the one read last cycle
        ram_we = pend_r;
        if (cnt_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_r[IDX_W-1:0];
          wa_nxt    = up_r ? src_r + CNT_W'(1) : src_r - CNT_W'(1);
          src_nxt   = up_r ? src_r - CNT_W'(1) : src_r + CNT_W'(1);
          cnt_nxt   = cnt_r - CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = up_r ? S_PUT : S_RESP;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IDX_W-1:0];
        ram_wdata = key_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_pos_nxt    = pos_ext[POS_W-1:0];
          out_status_nxt = status_r;
          out_count_nxt  = used_ext[POS_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hix_r        <= hix_nxt;
    mid_r        <= mid_nxt;
    hit_r        <= hit_nxt;
    pos_r        <= pos_nxt;
    src_r        <= src_nxt;
    cnt_r        <= cnt_nxt;
    wa_r         <= wa_nxt;
    up_r         <= up_nxt;
    status_r     <= status_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cap_r       <= CAP_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cap_r       <= cap_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_position      = out_pos_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;

  a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(DEPTH))
    else $error("key count exceeds table depth");

  a_put_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (pos_r < used_r))
    else $error("insert position beyond key count");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_RD || state_r == S_SRCH_CMP || state_r == S_IDLE) |-> !ram_we)
    else $error("key store written outside an update");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_RD) |-> (lo_r < hix_r && hix_r <= used_r))
    else $error("search window empty or beyond key count");

  a_used_stable_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_CMP) |-> $stable(used_r))
    else $error("key count changed during search");

endmodule
